[rtl/hvn_pkg.sv]
// shared constants and helpers for the hashed value noise pipeline
`default_nettype none

package hvn_pkg;

    // datapath widths
    localparam int WORD_W   = 32;
    localparam int VALUE_W  = 24;
    localparam int WEIGHT_W = 16;
    localparam int SMOOTH_K_W = WEIGHT_W + 2;

    // default number of fraction bits on the coordinates
    localparam int FRAC_BITS_DEFAULT = 16;

    // register stages from input capture to the output register
    localparam int NUM_STAGES = 15;

    // hash constants
    localparam logic [WORD_W-1:0] HASH_GOLDEN = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 32'h7feb_352d;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 32'h846c_a68b;
    localparam int MIX_SHIFT_HI = 16;
    localparam int MIX_SHIFT_LO = 15;
    localparam int COMB_SHL = 6;
    localparam int COMB_SHR = 2;

    // 3.0 in Q2.16, the constant term of the smoothing cubic
    localparam logic [SMOOTH_K_W-1:0] SMOOTH_THREE = 18'd196608;

    // seed/value combine ahead of the mix
    function automatic logic [WORD_W-1:0] hash_pre(
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] v
    );
        return s ^ (v + HASH_GOLDEN + (s << COMB_SHL) + (s >> COMB_SHR));
    endfunction

endpackage

`default_nettype wire

[rtl/hvn_mix.sv]
// two-stage xor-shift-multiply integer mix
`default_nettype none

module hvn_mix (
    input  wire logic                       clk,
    input  wire logic [1:0]                 en,
    input  wire logic [hvn_pkg::WORD_W-1:0] din,
    output logic      [hvn_pkg::WORD_W-1:0] dout
);
    import hvn_pkg::*;

    logic [WORD_W-1:0] pre_a;
    logic [WORD_W-1:0] pre_b;
    logic [WORD_W-1:0] mul_a_next;
    logic [WORD_W-1:0] mul_a_reg;
    logic [WORD_W-1:0] mul_b_next;
    logic [WORD_W-1:0] mul_b_reg;

    // first xor-shift and multiply, then second xor-shift and multiply
    always_comb
    begin
        pre_a      = din ^ (din >> MIX_SHIFT_HI);
        mul_a_next = pre_a * MIX_MUL_A;
        pre_b      = mul_a_reg ^ (mul_a_reg >> MIX_SHIFT_LO);
        mul_b_next = pre_b * MIX_MUL_B;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mul_a_reg <= mul_a_next;
        end
        if (en[1])
        begin
            mul_b_reg <= mul_b_next;
        end
    end

    // final xor-shift
    assign dout = mul_b_reg ^ (mul_b_reg >> MIX_SHIFT_HI);

endmodule

`default_nettype wire

[rtl/hashed_value_noise_2d.sv]
// top level of the hashed 2D value noise generator
// Hashed 2D value noise: each beat carries a point (x_coord, y_coord) in
// signed fixed point with FRAC_BITS fraction bits and a 32-bit noise_seed,
// and returns one noise_value in unsigned Q0.24. The block is a fifteen-stage
// pipeline: input capture, two chained seed/coordinate hashes and a final mix
// per lattice corner (each mix is two registered 32x32 multiplies), then the
// smoothed bilinear blend, x first and then y. It takes one beat per clock
// cycle sustained while noise_ready is high. Each stage holds its beat when
// the stage after it is full and stalled, and empty stages keep filling, so a
// waiting result blocks new input only once every stage holds a beat.
`default_nettype none

module hashed_value_noise_2d #(
    parameter int FRAC_BITS = hvn_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_ready,
    input  wire logic signed [hvn_pkg::WORD_W-1:0]  x_coord,
    input  wire logic signed [hvn_pkg::WORD_W-1:0]  y_coord,
    input  wire logic        [hvn_pkg::WORD_W-1:0]  noise_seed,
    output logic                                    noise_valid,
    input  wire logic                               noise_ready,
    output logic             [hvn_pkg::VALUE_W-1:0] noise_value
);
    import hvn_pkg::*;

    localparam int PROD_W   = VALUE_W + WEIGHT_W;
    localparam int SMPROD_W = 2 * WEIGHT_W + SMOOTH_K_W;

    // stage control
    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] valid_next;
    logic [NUM_STAGES:1] en;

    // stage 1: lattice corners and fractions
    logic [WORD_W-1:0]   seed_s1_reg;
    logic [WORD_W-1:0]   x0_s1_reg;
    logic [WORD_W-1:0]   x1_s1_reg;
    logic [WEIGHT_W-1:0] tx_s1_reg;
    logic [WEIGHT_W-1:0] ty_s1_reg;
    logic [WORD_W-1:0]   x0_next;
    logic [WORD_W-1:0]   y0_next;
    logic [WEIGHT_W-1:0] tx_next;
    logic [WEIGHT_W-1:0] ty_next;
    logic [WORD_W-1:0]   y0_reg [1:4];
    logic [WORD_W-1:0]   y1_reg [1:4];

    // stage 2: first combine, smoothing square
    logic [WORD_W-1:0]     w_s2_reg [2];
    logic [2*WEIGHT_W-1:0] ttx_s2_reg;
    logic [2*WEIGHT_W-1:0] tty_s2_reg;
    logic [SMOOTH_K_W-1:0] kx_s2_reg;
    logic [SMOOTH_K_W-1:0] ky_s2_reg;

    // stage 3 onward: smoothed weights
    logic [SMPROD_W-1:0] smx_prod;
    logic [SMPROD_W-1:0] smy_prod;
    logic [WEIGHT_W-1:0] sx_reg [3:10];
    logic [WEIGHT_W-1:0] sy_reg [3:13];

    // hash chain
    logic [WORD_W-1:0] c_hash [2];
    logic [WORD_W-1:0] kp_s5_reg [2][2];
    logic [WORD_W-1:0] key_hash [2][2];
    logic [WORD_W-1:0] val_hash [2][2];

    // x blend, one row per y corner
    logic [VALUE_W-1:0] xa_s10_reg [2];
    logic [VALUE_W-1:0] xmag_s10_reg [2];
    logic               xneg_s10_reg [2];
    logic [VALUE_W-1:0] xa_s11_reg [2];
    logic [VALUE_W-1:0] xprod_s11_reg [2];
    logic               xneg_s11_reg [2];
    logic [PROD_W-1:0]  xprod_full [2];
    logic [VALUE_W-1:0] row_s12_reg [2];

    // y blend
    logic [VALUE_W-1:0] ya_s13_reg;
    logic [VALUE_W-1:0] ymag_s13_reg;
    logic               yneg_s13_reg;
    logic [VALUE_W-1:0] ya_s14_reg;
    logic [VALUE_W-1:0] yprod_s14_reg;
    logic               yneg_s14_reg;
    logic [PROD_W-1:0]  yprod_full;
    logic [VALUE_W-1:0] noise_reg;

    // stage enables: a stage loads when empty or when the next one moves
    always_comb
    begin
        en[NUM_STAGES] = !valid_reg[NUM_STAGES] || noise_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next[1] = en[1] ? item_valid : valid_reg[1];
        for (int k = 2; k <= NUM_STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign item_ready  = en[1];
    assign noise_valid = valid_reg[NUM_STAGES];
    assign noise_value = noise_reg;

    // integer part by arithmetic shift, fraction brought to Q0.16
    assign x0_next = WORD_W'(x_coord >>> FRAC_BITS);
    assign y0_next = WORD_W'(y_coord >>> FRAC_BITS);

    if (FRAC_BITS >= WEIGHT_W)
    begin : g_frac_trunc
        assign tx_next = x_coord[FRAC_BITS-1 -: WEIGHT_W];
        assign ty_next = y_coord[FRAC_BITS-1 -: WEIGHT_W];
    end
    else
    begin : g_frac_pad
        assign tx_next = {x_coord[FRAC_BITS-1:0], {(WEIGHT_W-FRAC_BITS){1'b0}}};
        assign ty_next = {y_coord[FRAC_BITS-1:0], {(WEIGHT_W-FRAC_BITS){1'b0}}};
    end

    // stage 1: capture
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            seed_s1_reg <= noise_seed;
            x0_s1_reg   <= x0_next;
            x1_s1_reg   <= x0_next + WORD_W'(1);
            y0_reg[1]   <= y0_next;
            y1_reg[1]   <= y0_next + WORD_W'(1);
            tx_s1_reg   <= tx_next;
            ty_s1_reg   <= ty_next;
        end
    end

    // y corners travel until the second combine
    for (genvar k = 2; k <= 4; k++)
    begin : g_y_delay
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                y0_reg[k] <= y0_reg[k-1];
                y1_reg[k] <= y1_reg[k-1];
            end
        end
    end

    // stage 2: seed with x corner, and t*t with 3-2t
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            w_s2_reg[0] <= hash_pre(seed_s1_reg, x0_s1_reg);
            w_s2_reg[1] <= hash_pre(seed_s1_reg, x1_s1_reg);
            ttx_s2_reg  <= (2*WEIGHT_W)'(tx_s1_reg) * (2*WEIGHT_W)'(tx_s1_reg);
            tty_s2_reg  <= (2*WEIGHT_W)'(ty_s1_reg) * (2*WEIGHT_W)'(ty_s1_reg);
            kx_s2_reg   <= SMOOTH_THREE - {1'b0, tx_s1_reg, 1'b0};
            ky_s2_reg   <= SMOOTH_THREE - {1'b0, ty_s1_reg, 1'b0};
        end
    end

    // stage 3: smoothed weight, upper word of the cubic product
    assign smx_prod = SMPROD_W'(ttx_s2_reg) * SMPROD_W'(kx_s2_reg);
    assign smy_prod = SMPROD_W'(tty_s2_reg) * SMPROD_W'(ky_s2_reg);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            sx_reg[3] <= smx_prod[3*WEIGHT_W-1:2*WEIGHT_W];
            sy_reg[3] <= smy_prod[3*WEIGHT_W-1:2*WEIGHT_W];
        end
    end

    for (genvar k = 4; k <= 10; k++)
    begin : g_sx_delay
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                sx_reg[k] <= sx_reg[k-1];
            end
        end
    end

    for (genvar k = 4; k <= 13; k++)
    begin : g_sy_delay
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                sy_reg[k] <= sy_reg[k-1];
            end
        end
    end

    // stages 3-4: mix of the first combine
    for (genvar i = 0; i < 2; i++)
    begin : g_mix_col
        hvn_mix u_mix_col (
            .clk  (clk),
            .en   (en[4:3]),
            .din  (w_s2_reg[i]),
            .dout (c_hash[i])
        );
    end

    // stage 5: column hash with y corner
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int i = 0; i < 2; i++)
            begin
                kp_s5_reg[i][0] <= hash_pre(c_hash[i], y0_reg[4]);
                kp_s5_reg[i][1] <= hash_pre(c_hash[i], y1_reg[4]);
            end
        end
    end

    // stages 6-9: corner key mix, then value mix
    for (genvar i = 0; i < 2; i++)
    begin : g_corner_i
        for (genvar j = 0; j < 2; j++)
        begin : g_corner_j
            hvn_mix u_mix_key (
                .clk  (clk),
                .en   (en[7:6]),
                .din  (kp_s5_reg[i][j]),
                .dout (key_hash[i][j])
            );

            hvn_mix u_mix_val (
                .clk  (clk),
                .en   (en[9:8]),
                .din  (key_hash[i][j]),
                .dout (val_hash[i][j])
            );
        end
    end

    // stages 10-12: x blend for both rows, delta taken as magnitude and sign
    for (genvar r = 0; r < 2; r++)
    begin : g_row
        logic [VALUE_W-1:0] ca;
        logic [VALUE_W-1:0] cb;

        assign ca = val_hash[0][r][VALUE_W-1:0];
        assign cb = val_hash[1][r][VALUE_W-1:0];
        assign xprod_full[r] = PROD_W'(xmag_s10_reg[r]) * PROD_W'(sx_reg[10]);

        always_ff @(posedge clk)
        begin
            if (en[10])
            begin
                xa_s10_reg[r]   <= ca;
                xneg_s10_reg[r] <= cb < ca;
                xmag_s10_reg[r] <= (cb < ca) ? (ca - cb) : (cb - ca);
            end
            if (en[11])
            begin
                xa_s11_reg[r]    <= xa_s10_reg[r];
                xneg_s11_reg[r]  <= xneg_s10_reg[r];
                xprod_s11_reg[r] <= xprod_full[r][PROD_W-1:WEIGHT_W];
            end
            if (en[12])
            begin
                row_s12_reg[r] <= xneg_s11_reg[r] ? (xa_s11_reg[r] - xprod_s11_reg[r])
                                                  : (xa_s11_reg[r] + xprod_s11_reg[r]);
            end
        end
    end

    // stages 13-15: y blend between the two rows
    assign yprod_full = PROD_W'(ymag_s13_reg) * PROD_W'(sy_reg[13]);

    always_ff @(posedge clk)
    begin
        if (en[13])
        begin
            ya_s13_reg   <= row_s12_reg[0];
            yneg_s13_reg <= row_s12_reg[1] < row_s12_reg[0];
            ymag_s13_reg <= (row_s12_reg[1] < row_s12_reg[0])
                          ? (row_s12_reg[0] - row_s12_reg[1])
                          : (row_s12_reg[1] - row_s12_reg[0]);
        end
        if (en[14])
        begin
            ya_s14_reg    <= ya_s13_reg;
            yneg_s14_reg  <= yneg_s13_reg;
            yprod_s14_reg <= yprod_full[PROD_W-1:WEIGHT_W];
        end
        if (en[15])
        begin
            noise_reg <= yneg_s14_reg ? (ya_s14_reg - yprod_s14_reg)
                                      : (ya_s14_reg + yprod_s14_reg);
        end
    end

endmodule

`default_nettype wire
